>>> hdl/iuc_pkg.sv
// ----------------------------------------------------------------------------
// iuc_pkg: shared types and constants
// Widths, capacity and the queue word passed from the loader to the sweeper.
// ----------------------------------------------------------------------------
package iuc_pkg;

  localparam int unsigned MaxIntervals = 32;
  localparam int unsigned ValW  = 31;
  localparam int unsigned IdxW  = $clog2(MaxIntervals);
  localparam int unsigned CntW  = $clog2(MaxIntervals + 1);

  // one loaded set handed to the back part
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            overflow;
  } set_desc_t;

endpackage

>>> hdl/iuc_ram.sv
// ----------------------------------------------------------------------------
// iuc_ram: generic single-write, single-read RAM
// Registered read port.
// ----------------------------------------------------------------------------
module iuc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/iuc_front.sv
// ----------------------------------------------------------------------------
// iuc_front: interval loader
// Store each word, count it or flag the overflow, and hand the set on at last.
// ----------------------------------------------------------------------------
module iuc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [iuc_pkg::ValW-1:0]      interval_start_i,
  input  logic [iuc_pkg::ValW-1:0]      interval_end_i,
  input  logic                          is_last_i,
  output logic                          we_o,
  output logic [iuc_pkg::IdxW-1:0]      waddr_o,
  output logic [2*iuc_pkg::ValW-1:0]    wdata_o,
  output logic                          set_valid_o,
  output iuc_pkg::set_desc_t            set_o,
  input  logic                          set_full_i
);

  logic [iuc_pkg::CntW-1:0] count_q, count_d;
  logic                     ovf_q, ovf_d;
  logic                     accept, room;

  // the back part reads the shared store, so hold off while a set is pending
  assign stall_o = set_full_i;
  assign accept  = valid_i && !stall_o;
  assign room    = count_q < iuc_pkg::CntW'(iuc_pkg::MaxIntervals);

  assign we_o    = accept && room;
  assign waddr_o = count_q[iuc_pkg::IdxW-1:0];
  assign wdata_o = {interval_start_i, interval_end_i};

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    set_valid_o    = 1'b0;
    set_o.count    = count_q + iuc_pkg::CntW'(room);
    set_o.overflow = ovf_q || !room;
    if (accept) begin
      if (room) begin
        count_d = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      if (is_last_i) begin
        set_valid_o = 1'b1;
        count_d     = '0;
        ovf_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= iuc_pkg::CntW'(iuc_pkg::MaxIntervals))
    else $error("loader count beyond capacity");
  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_full_i |-> !we_o)
    else $error("store written while set pending");
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_valid_o |=> (count_q == '0 && !ovf_q))
    else $error("loader not cleared after last");

endmodule

>>> hdl/iuc_back.sv
// ----------------------------------------------------------------------------
// iuc_back: sorter and gap sweeper
// Odd-even transposition sort in the register file, then one sweep that emits the gaps.
// ----------------------------------------------------------------------------
module iuc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          set_valid_i,
  input  iuc_pkg::set_desc_t            set_i,
  output logic                          set_full_o,
  output logic [iuc_pkg::IdxW-1:0]      raddr_o,
  input  logic [2*iuc_pkg::ValW-1:0]    rdata_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [iuc_pkg::ValW-1:0]      gap_low_o,
  output logic [iuc_pkg::ValW-1:0]      gap_high_o,
  output logic                          gap_open_ended_o,
  output logic                          too_many_o,
  output logic                          last_gap_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StLoad  = 2'd1;
  localparam logic [1:0] StSort  = 2'd2;
  localparam logic [1:0] StSweep = 2'd3;

  localparam int unsigned N = iuc_pkg::MaxIntervals;
  localparam int unsigned W = iuc_pkg::ValW;

  logic [1:0]               state_q, state_d;
  iuc_pkg::set_desc_t       desc_q;
  logic                     desc_full_q, desc_full_d;
  logic [iuc_pkg::CntW-1:0] idx_q, idx_d;
  logic                     rd_pend_q;
  logic [W-1:0]             s_q [N];
  logic [W-1:0]             e_q [N];
  logic                     phase_q, phase_d;
  logic                     swapped_q, swapped_d;
  logic [W:0]               reach_q, reach_d;
  logic                     out_valid_q, out_valid_d;
  logic [W-1:0]             lo_q, lo_d, hi_q, hi_d;
  logic                     open_q, open_d, last_q, last_d;
  logic                     tm_q, tm_d;
  logic                     out_free;
  logic [W-1:0]             cur_s, cur_e, top;
  logic [W:0]               top1;

  assign set_full_o = desc_full_q;
  assign out_free   = !out_valid_q || !stall_i;
  assign raddr_o    = idx_q[iuc_pkg::IdxW-1:0];

  assign cur_s = s_q[idx_q[iuc_pkg::IdxW-1:0]];
  assign cur_e = e_q[idx_q[iuc_pkg::IdxW-1:0]];
  assign top   = (cur_e > cur_s) ? cur_e : cur_s;
  assign top1  = {1'b0, top} + 1'b1;

  // odd-even transposition: compare-swap all pairs of one parity per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == StLoad && rd_pend_q) begin
      s_q[idx_q[iuc_pkg::IdxW-1:0] - 1'b1] <= rdata_i[2*W-1:W];
      e_q[idx_q[iuc_pkg::IdxW-1:0] - 1'b1] <= rdata_i[W-1:0];
    end else if (state_q == StSort) begin
      for (int i = 0; i < N - 1; i++) begin
        if (i[0] == phase_q && (i + 1) < int'(desc_q.count) && s_q[i] > s_q[i+1]) begin
          s_q[i]   <= s_q[i+1];
          s_q[i+1] <= s_q[i];
          e_q[i]   <= e_q[i+1];
          e_q[i+1] <= e_q[i];
        end
      end
    end
  end

  logic any_swap;
  always_comb begin
    any_swap = 1'b0;
    for (int i = 0; i < N - 1; i++) begin
      if (i[0] == phase_q && (i + 1) < int'(desc_q.count) && s_q[i] > s_q[i+1]) begin
        any_swap = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    desc_full_d = desc_full_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    swapped_d   = swapped_q;
    reach_d     = reach_q;
    out_valid_d = out_valid_q && stall_i;
    lo_d = lo_q; hi_d = hi_q; open_d = open_q; last_d = last_q;
    tm_d = tm_q;
    case (state_q)
      StIdle: begin
        if (desc_full_q) begin
          state_d = StLoad;
          idx_d   = '0;
        end
      end
      StLoad: begin
        // one read per cycle; the data lands in the next cycle
        if (idx_q == desc_q.count) begin
          if (rd_pend_q || desc_q.count == '0) begin
            state_d   = StSort;
            phase_d   = 1'b0;
            swapped_d = 1'b0;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StSort: begin
        phase_d   = !phase_q;
        swapped_d = phase_q ? 1'b0 : any_swap;
        // stop after an odd phase when neither phase swapped
        if (phase_q && !swapped_q && !any_swap) begin
          state_d = StSweep;
          idx_d   = '0;
          reach_d = (W+1)'(1);
        end
      end
      StSweep: begin
        if (out_free) begin
          if (idx_q == desc_q.count) begin
            out_valid_d = 1'b1;
            lo_d = reach_q[W-1:0]; hi_d = '0; open_d = 1'b1; last_d = 1'b1;
            tm_d = desc_q.overflow;
            state_d     = StIdle;
            desc_full_d = 1'b0;
          end else begin
            if (reach_q < {1'b0, cur_s}) begin
              out_valid_d = 1'b1;
              lo_d = reach_q[W-1:0]; hi_d = cur_s - 1'b1;
              open_d = 1'b0; last_d = 1'b0;
              tm_d = desc_q.overflow;
            end
            if (top1 > reach_q) begin
              reach_d = top1;
            end
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    if (set_valid_i) begin
      desc_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_valid_i) begin
      desc_q <= set_i;
    end
    lo_q <= lo_d; hi_q <= hi_d; open_q <= open_d; last_q <= last_d;
    tm_q <= tm_d;
    reach_q <= reach_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      desc_full_q <= 1'b0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      phase_q     <= 1'b0;
      swapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      desc_full_q <= desc_full_d;
      idx_q       <= idx_d;
      rd_pend_q   <= (state_q == StLoad) && (idx_q != desc_q.count);
      phase_q     <= phase_d;
      swapped_q   <= swapped_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign valid_o          = out_valid_q;
  assign gap_low_o        = lo_q;
  assign gap_high_o       = hi_q;
  assign gap_open_ended_o = open_q;
  assign too_many_o       = tm_q;
  assign last_gap_o       = last_q;

  a_last_is_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_gap_o == gap_open_ended_o))
    else $error("last flag and open end disagree");
  a_no_set_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_valid_i |-> !desc_full_q)
    else $error("set handed over while busy");
  a_idle_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !desc_full_q |-> state_q == StIdle)
    else $error("sequencer active without a set");
  a_gap_from_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> gap_low_o != '0)
    else $error("gap below one");

endmodule

>>> hdl/interval_union_complement.sv
// ----------------------------------------------------------------------------
// interval_union_complement: gaps in a union of closed intervals
// Loads a set of intervals, sorts and merges them, then emits the gaps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid_i/stall_o): one word per interval, start, end and
//   is_last. A non-last word is taken and gives no result.
//   Words beyond 32 are dropped; too_many_o then stays high for the set.
//   Output channel (valid_o/stall_i): one word per gap, ascending, then an
//   open-ended word marked last_gap_o. gap_high_o is zero in that word.
//   Sequence: after the last word, the n intervals are copied from the store
//   into the sort registers, odd-even compare-swap passes sort them, and the
//   sweep takes one interval per cycle while the receiver does not stall,
//   then emits the open-ended word. The input takes one word per cycle when
//   it is not stalled.
//   While a set is being processed the input stalls; the next set's words
//   are taken once its last result is registered.
//   Reset clears all control; the interval store needs no clearing.
//   A stalled receiver holds the output word and freezes the sweep.
// ----------------------------------------------------------------------------
module interval_union_complement (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [iuc_pkg::ValW-1:0] interval_start_i,
  input  logic [iuc_pkg::ValW-1:0] interval_end_i,
  input  logic                     is_last_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic [iuc_pkg::ValW-1:0] gap_low_o,
  output logic [iuc_pkg::ValW-1:0] gap_high_o,
  output logic                     gap_open_ended_o,
  output logic                     too_many_o,
  output logic                     last_gap_o
);

  // store write side from the loader
  logic                          we;
  logic [iuc_pkg::IdxW-1:0]      waddr, raddr;
  logic [2*iuc_pkg::ValW-1:0]    wdata, rdata;
  // one-entry queue of finished sets between loader and sweeper
  logic                          set_valid, set_full;
  iuc_pkg::set_desc_t            set_desc;

  iuc_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .interval_start_i, .interval_end_i, .is_last_i,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .set_valid_o(set_valid), .set_o(set_desc), .set_full_i(set_full)
  );

  // interval store: start and end packed in one word
  iuc_ram #(
    .Width(2 * iuc_pkg::ValW),
    .Depth(iuc_pkg::MaxIntervals)
  ) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  iuc_back u_back (
    .clk_i, .rst_ni,
    .set_valid_i(set_valid), .set_i(set_desc), .set_full_o(set_full),
    .raddr_o(raddr), .rdata_i(rdata),
    .valid_o, .stall_i,
    .gap_low_o, .gap_high_o, .gap_open_ended_o, .too_many_o, .last_gap_o
  );

endmodule
